FILE: src/assert_macros.svh
// Assertion macros shared by the particle pool RTL.
// Used by the top level; expands to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PPU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PPU_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PPU_ASSERT(lbl, prop, msg)
`define PPU_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: src/ppu_pkg.sv
// Package for the particle pool update core: sizes, codes and shared types.
// Used by ppu_ctrl, ppu_dpath and particle_pool_update_core.
`default_nettype none
package ppu_pkg;
	localparam int NUM_SLOTS  = 64;
	localparam int SLOT_W     = $clog2(NUM_SLOTS);
	localparam int LIVE_W     = $clog2(NUM_SLOTS + 1);
	localparam int REPORT_MAX = 64;
	localparam int REP_N      = (NUM_SLOTS < REPORT_MAX) ? NUM_SLOTS : REPORT_MAX;
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_SLOTS - 1);
	localparam logic [SLOT_W-1:0] REP_LAST  = SLOT_W'(REP_N - 1);

	localparam int IN_DATA_W  = 312;
	localparam int OUT_DATA_W = 168;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 31;

	localparam logic [CFG_IDX_W-1:0] REG_EFFECTS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRAVITY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DRAG    = 2'd2;

	localparam logic [30:0] GRAV_RESET = 31'd32768000;
	localparam logic [16:0] DRAG_RESET = 17'd64225;
	localparam logic [16:0] FRAC_ONE   = 17'd65536;

	localparam logic [2:0] PT_DEBRIS = 3'd0;
	localparam logic [2:0] PT_SMOKE  = 3'd3;
	localparam logic [2:0] PT_SHELL  = 3'd4;

	localparam logic CMD_TICK = 1'b1;

	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_NONE       = 4'd0;
	localparam logic [OP_W-1:0] OP_CAPTURE    = 4'd1;
	localparam logic [OP_W-1:0] OP_READ       = 4'd2;
	localparam logic [OP_W-1:0] OP_SCAN_CMP   = 4'd3;
	localparam logic [OP_W-1:0] OP_CREATE_WR  = 4'd4;
	localparam logic [OP_W-1:0] OP_OUT_CREATE = 4'd5;
	localparam logic [OP_W-1:0] OP_OUT_DROP   = 4'd6;
	localparam logic [OP_W-1:0] OP_LOAD       = 4'd7;
	localparam logic [OP_W-1:0] OP_MUL        = 4'd8;
	localparam logic [OP_W-1:0] OP_APPLY      = 4'd9;
	localparam logic [OP_W-1:0] OP_DIV_INIT   = 4'd10;
	localparam logic [OP_W-1:0] OP_DIV_STEP   = 4'd11;
	localparam logic [OP_W-1:0] OP_BLEND      = 4'd12;
	localparam logic [OP_W-1:0] OP_TICK_WR    = 4'd13;
	localparam logic [OP_W-1:0] OP_OUT_REPORT = 4'd14;
	localparam logic [OP_W-1:0] OP_CLR_SHOW   = 4'd15;

	localparam logic [3:0] MUL_LAST   = 4'd5;
	localparam logic [3:0] DIV_LAST   = 4'd15;
	localparam logic [3:0] BLEND_LAST = 4'd3;

	typedef struct packed {
		logic        pad;
		logic [15:0] frame_time;
		logic [2:0]  particle_type;
		logic [63:0] colors;
		logic [19:0] lifetime;
		logic [15:0] size;
		logic [31:0] rotation_speed;
		logic [31:0] rotation;
		logic [31:0] vel_y;
		logic [31:0] vel_x;
		logic [31:0] pos_y;
		logic [31:0] pos_x;
	} in_item_t;

	typedef struct packed {
		logic [6:0]  pad;
		logic [6:0]  live_total;
		logic [2:0]  out_type;
		logic [31:0] out_color;
		logic [15:0] out_size;
		logic [31:0] out_rotation;
		logic [31:0] out_pos_y;
		logic [31:0] out_pos_x;
		logic        alive;
		logic [5:0]  slot;
	} out_item_t;

	typedef struct packed {
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] vel_x;
		logic [31:0] vel_y;
		logic [31:0] angle;
		logic [31:0] spin;
		logic [15:0] size;
		logic [20:0] rem;
		logic [19:0] init;
		logic [63:0] colors;
		logic [31:0] color;
		logic [2:0]  ptype;
	} slot_rec_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [SLOT_W-1:0] idx;
		logic [3:0]        sub;
		logic              last;
	} ctl_cmd_t;

	typedef struct packed {
		logic live;
		logic enabled;
		logic out_free;
	} dp_stat_t;
endpackage
`default_nettype wire

FILE: src/ppu_ctrl.sv
// Sequencer of the particle pool: walks the slots for creates, ticks and reports.
// Depends on ppu_pkg; drives the datapath through ctl_cmd_t.
`default_nettype none
module ppu_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             in_cmd,
	output logic                  in_ready,
	input  wire ppu_pkg::dp_stat_t stat,
	output ppu_pkg::ctl_cmd_t     cmd
);
	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_SCAN_RD  = 4'd1;
	localparam logic [3:0] S_SCAN_CMP = 4'd2;
	localparam logic [3:0] S_CR_WR    = 4'd3;
	localparam logic [3:0] S_CR_OUT   = 4'd4;
	localparam logic [3:0] S_DROP_OUT = 4'd5;
	localparam logic [3:0] S_T_RD     = 4'd6;
	localparam logic [3:0] S_T_LD     = 4'd7;
	localparam logic [3:0] S_T_MUL    = 4'd8;
	localparam logic [3:0] S_T_APPLY  = 4'd9;
	localparam logic [3:0] S_T_DIV0   = 4'd10;
	localparam logic [3:0] S_T_DIV    = 4'd11;
	localparam logic [3:0] S_T_BLEND  = 4'd12;
	localparam logic [3:0] S_T_WR     = 4'd13;
	localparam logic [3:0] S_R_RD     = 4'd14;
	localparam logic [3:0] S_R_OUT    = 4'd15;

	logic [3:0]                 state_q, state_d;
	logic [ppu_pkg::SLOT_W-1:0] idx_q, idx_d;
	logic [3:0]                 step_q, step_d;

	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		step_d   = step_q;
		in_ready = 1'b0;
		cmd.op   = ppu_pkg::OP_NONE;
		cmd.idx  = idx_q;
		cmd.sub  = step_q;
		cmd.last = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = ppu_pkg::OP_CAPTURE;
					idx_d  = '0;
					step_d = '0;
					if (in_cmd == ppu_pkg::CMD_TICK) state_d = S_T_RD;
					else if (!stat.enabled) state_d = S_DROP_OUT;
					else state_d = S_SCAN_RD;
				end
			end
			S_SCAN_RD: begin
				cmd.op  = ppu_pkg::OP_READ;
				state_d = S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				cmd.op = ppu_pkg::OP_SCAN_CMP;
				if (idx_q == ppu_pkg::SLOT_LAST) begin
					state_d = S_CR_WR;
				end else begin
					idx_d   = idx_q + 1'b1;
					state_d = S_SCAN_RD;
				end
			end
			S_CR_WR: begin
				cmd.op  = ppu_pkg::OP_CREATE_WR;
				state_d = S_CR_OUT;
			end
			S_CR_OUT: begin
				if (stat.out_free) begin
					cmd.op  = ppu_pkg::OP_OUT_CREATE;
					state_d = S_IDLE;
				end
			end
			S_DROP_OUT: begin
				if (stat.out_free) begin
					cmd.op  = ppu_pkg::OP_OUT_DROP;
					state_d = S_IDLE;
				end
			end
			S_T_RD: begin
				if (stat.live) begin
					cmd.op  = ppu_pkg::OP_READ;
					state_d = S_T_LD;
				end else begin
					// A free slot is not updated, but its expiry mark is dropped.
					cmd.op = ppu_pkg::OP_CLR_SHOW;
					if (idx_q == ppu_pkg::SLOT_LAST) begin
						idx_d   = '0;
						state_d = S_R_RD;
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end
			end
			S_T_LD: begin
				cmd.op  = ppu_pkg::OP_LOAD;
				step_d  = '0;
				state_d = S_T_MUL;
			end
			S_T_MUL: begin
				cmd.op  = ppu_pkg::OP_MUL;
				state_d = S_T_APPLY;
			end
			S_T_APPLY: begin
				cmd.op = ppu_pkg::OP_APPLY;
				if (step_q == ppu_pkg::MUL_LAST) begin
					step_d  = '0;
					state_d = S_T_DIV0;
				end else begin
					step_d  = step_q + 1'b1;
					state_d = S_T_MUL;
				end
			end
			S_T_DIV0: begin
				cmd.op  = ppu_pkg::OP_DIV_INIT;
				step_d  = '0;
				state_d = S_T_DIV;
			end
			S_T_DIV: begin
				cmd.op = ppu_pkg::OP_DIV_STEP;
				if (step_q == ppu_pkg::DIV_LAST) begin
					step_d  = '0;
					state_d = S_T_BLEND;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			S_T_BLEND: begin
				cmd.op = ppu_pkg::OP_BLEND;
				if (step_q == ppu_pkg::BLEND_LAST) begin
					step_d  = '0;
					state_d = S_T_WR;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			S_T_WR: begin
				cmd.op = ppu_pkg::OP_TICK_WR;
				if (idx_q == ppu_pkg::SLOT_LAST) begin
					idx_d   = '0;
					state_d = S_R_RD;
				end else begin
					idx_d   = idx_q + 1'b1;
					state_d = S_T_RD;
				end
			end
			S_R_RD: begin
				cmd.op  = ppu_pkg::OP_READ;
				state_d = S_R_OUT;
			end
			S_R_OUT: begin
				cmd.last = (idx_q == ppu_pkg::REP_LAST);
				if (stat.out_free) begin
					cmd.op = ppu_pkg::OP_OUT_REPORT;
					if (idx_q == ppu_pkg::REP_LAST) begin
						idx_d   = '0;
						state_d = S_IDLE;
					end else begin
						idx_d   = idx_q + 1'b1;
						state_d = S_R_RD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			step_q  <= step_d;
		end
	end
endmodule
`default_nettype wire

FILE: src/ppu_dpath.sv
// Datapath of the particle pool: slot memory, live flags, shared multiplier,
// life-fraction divider, color blend and the output register. Depends on ppu_pkg.
`default_nettype none
module ppu_dpath (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire ppu_pkg::ctl_cmd_t                  cmd,
	output ppu_pkg::dp_stat_t                       stat,
	input  wire ppu_pkg::in_item_t                  in_item,
	input  wire logic                               cfg_valid,
	input  wire logic [ppu_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [ppu_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output ppu_pkg::out_item_t                      out_item,
	output logic                                    out_last
);
	function automatic logic [31:0] sat32(input logic signed [51:0] v);
		logic [31:0] r;
		if (v > 52'sd2147483647) r = 32'h7FFF_FFFF;
		else if (v < -52'sd2147483648) r = 32'h8000_0000;
		else r = v[31:0];
		return r;
	endfunction

	// Control state.
	logic [ppu_pkg::NUM_SLOTS-1:0] live_q, show_q;
	logic [ppu_pkg::LIVE_W-1:0]    count_q;
	logic                          enabled_q;
	logic [30:0]                   grav_q;
	logic [16:0]                   drag_q;
	logic                          out_valid_q;
	logic                          div_run_q;
	logic                          free_found_q;

	// Payload.
	ppu_pkg::in_item_t             in_q;
	ppu_pkg::slot_rec_t            mem_q [ppu_pkg::NUM_SLOTS];
	ppu_pkg::slot_rec_t            rd_q, wk_q, new_rec, wr_data, ld_rec;
	logic                          wr_en;
	logic [ppu_pkg::SLOT_W-1:0]    wr_addr;
	logic signed [50:0]            prod_q;
	logic [16:0]                   f_q;
	logic [19:0]                   div_r_q;
	logic [ppu_pkg::SLOT_W-1:0]    free_idx_q, min_idx_q, cr_slot_q, cr_sel;
	logic signed [20:0]            min_rem_q;
	ppu_pkg::out_item_t            out_q, drop_item, rep_item;
	logic                          out_last_q;
	logic                          out_load;

	logic [16:0]        drag_eff;
	logic signed [32:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [51:0] ext_p, ext_base;
	logic [31:0]        sum_sat, scl_sat;
	logic [20:0]        div_t;
	logic               div_ge;
	logic [1:0]         ch;
	logic [7:0]         ch_a, ch_b;
	logic [24:0]        part_a, part_b;
	logic [25:0]        ch_sum;
	logic               expire;
	logic               is_grav, is_smoke;

	assign drag_eff = (drag_q > ppu_pkg::FRAC_ONE) ? ppu_pkg::FRAC_ONE : drag_q;
	assign is_grav  = (wk_q.ptype == ppu_pkg::PT_DEBRIS) || (wk_q.ptype == ppu_pkg::PT_SHELL);
	assign is_smoke = (wk_q.ptype == ppu_pkg::PT_SMOKE);
	assign cr_sel   = free_found_q ? free_idx_q : min_idx_q;
	assign expire   = ($signed(wk_q.rem) <= 21'sd0);
	assign out_load = (cmd.op == ppu_pkg::OP_OUT_CREATE) || (cmd.op == ppu_pkg::OP_OUT_DROP) ||
		(cmd.op == ppu_pkg::OP_OUT_REPORT);

	// Operand select for the shared multiplier.
	always_comb begin
		mul_a = {{1{wk_q.vel_x[31]}}, wk_q.vel_x};
		mul_b = {2'b00, in_q.frame_time};
		case (cmd.sub[2:0])
			3'd0: mul_a = {wk_q.vel_x[31], wk_q.vel_x};
			3'd1: mul_a = {wk_q.vel_y[31], wk_q.vel_y};
			3'd2: mul_a = {wk_q.spin[31], wk_q.spin};
			3'd3: mul_a = {2'b00, grav_q};
			3'd4: begin
				mul_a = {wk_q.vel_x[31], wk_q.vel_x};
				mul_b = {1'b0, drag_eff};
			end
			3'd5: begin
				mul_a = {wk_q.vel_y[31], wk_q.vel_y};
				mul_b = {1'b0, drag_eff};
			end
			default: ;
		endcase
	end

	// Product shifted down by 16 (floor) and added to the base of this step.
	always_comb begin
		ext_p = {{17{prod_q[50]}}, prod_q[50:16]};
		case (cmd.sub[2:0])
			3'd0:    ext_base = {{20{wk_q.pos_x[31]}}, wk_q.pos_x};
			3'd1:    ext_base = {{20{wk_q.pos_y[31]}}, wk_q.pos_y};
			3'd2:    ext_base = {{20{wk_q.angle[31]}}, wk_q.angle};
			3'd3:    ext_base = {{20{wk_q.vel_y[31]}}, wk_q.vel_y};
			default: ext_base = '0;
		endcase
		sum_sat = sat32(ext_base + ext_p);
		scl_sat = sat32(ext_p);
	end

	assign div_t  = {div_r_q, 1'b0};
	assign div_ge = (div_t >= {1'b0, wk_q.init});

	assign ch     = cmd.sub[1:0];
	assign ch_a   = wk_q.colors[{1'b1, ch, 3'b000} +: 8];
	assign ch_b   = wk_q.colors[{1'b0, ch, 3'b000} +: 8];
	assign part_a = ch_a * f_q;
	assign part_b = ch_b * (ppu_pkg::FRAC_ONE - f_q);
	assign ch_sum = {1'b0, part_a} + {1'b0, part_b};

	always_comb begin
		new_rec.pos_x  = in_q.pos_x;
		new_rec.pos_y  = in_q.pos_y;
		new_rec.vel_x  = in_q.vel_x;
		new_rec.vel_y  = in_q.vel_y;
		new_rec.angle  = in_q.rotation;
		new_rec.spin   = in_q.rotation_speed;
		new_rec.size   = in_q.size;
		new_rec.rem    = {1'b0, in_q.lifetime};
		new_rec.init   = in_q.lifetime;
		new_rec.colors = in_q.colors;
		new_rec.color  = in_q.colors[63:32];
		new_rec.ptype  = in_q.particle_type;
		wr_en   = 1'b0;
		wr_addr = cmd.idx;
		wr_data = wk_q;
		if (cmd.op == ppu_pkg::OP_TICK_WR) begin
			wr_en = 1'b1;
		end else if (cmd.op == ppu_pkg::OP_CREATE_WR) begin
			wr_en   = 1'b1;
			wr_addr = cr_sel;
			wr_data = new_rec;
		end
	end

	// Loaded slot with its life already decayed, and the result words.
	always_comb begin
		ld_rec     = rd_q;
		ld_rec.rem = rd_q.rem - {5'b0, in_q.frame_time};
		drop_item            = '0;
		drop_item.live_total = 7'(count_q);
		rep_item = '0;
		if (live_q[cmd.idx] || show_q[cmd.idx]) begin
			rep_item.out_type     = rd_q.ptype;
			rep_item.out_color    = rd_q.color;
			rep_item.out_size     = rd_q.size;
			rep_item.out_rotation = rd_q.angle;
			rep_item.out_pos_y    = rd_q.pos_y;
			rep_item.out_pos_x    = rd_q.pos_x;
		end
		rep_item.alive      = live_q[cmd.idx];
		rep_item.slot       = 6'(cmd.idx);
		rep_item.live_total = 7'(count_q);
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		if (cmd.op == ppu_pkg::OP_READ) rd_q <= mem_q[cmd.idx];
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			ppu_pkg::OP_CAPTURE: in_q <= in_item;
			ppu_pkg::OP_SCAN_CMP: begin
				if (cmd.idx == '0 || $signed(rd_q.rem) < min_rem_q) begin
					min_rem_q <= $signed(rd_q.rem);
					min_idx_q <= cmd.idx;
				end
				if (!live_q[cmd.idx] && (cmd.idx == '0 || !free_found_q))
					free_idx_q <= cmd.idx;
			end
			ppu_pkg::OP_CREATE_WR: cr_slot_q <= cr_sel;
			ppu_pkg::OP_LOAD: wk_q <= ld_rec;
			ppu_pkg::OP_MUL: prod_q <= mul_a * mul_b;
			ppu_pkg::OP_APPLY: begin
				case (cmd.sub[2:0])
					3'd0: wk_q.pos_x <= sum_sat;
					3'd1: wk_q.pos_y <= sum_sat;
					3'd2: wk_q.angle <= sum_sat;
					3'd3: if (is_grav) wk_q.vel_y <= sum_sat;
					3'd4: if (is_smoke) wk_q.vel_x <= scl_sat;
					3'd5: if (is_smoke) wk_q.vel_y <= scl_sat;
					default: ;
				endcase
			end
			ppu_pkg::OP_DIV_INIT: begin
				div_r_q <= wk_q.rem[19:0];
				if (expire) f_q <= '0;
				else if (wk_q.init == '0 || wk_q.rem >= {1'b0, wk_q.init})
					f_q <= ppu_pkg::FRAC_ONE;
				else f_q <= '0;
			end
			ppu_pkg::OP_DIV_STEP: begin
				if (div_run_q) begin
					div_r_q <= div_ge ? 20'(div_t - {1'b0, wk_q.init}) : div_t[19:0];
					f_q     <= {f_q[15:0], div_ge};
				end
			end
			ppu_pkg::OP_BLEND: wk_q.color[{ch, 3'b000} +: 8] <= ch_sum[23:16];
			ppu_pkg::OP_OUT_CREATE: begin
				out_q.pad          <= '0;
				out_q.live_total   <= 7'(count_q);
				out_q.out_type     <= in_q.particle_type;
				out_q.out_color    <= in_q.colors[63:32];
				out_q.out_size     <= in_q.size;
				out_q.out_rotation <= in_q.rotation;
				out_q.out_pos_y    <= in_q.pos_y;
				out_q.out_pos_x    <= in_q.pos_x;
				out_q.alive        <= 1'b1;
				out_q.slot         <= 6'(cr_slot_q);
				out_last_q         <= 1'b1;
			end
			ppu_pkg::OP_OUT_DROP: begin
				out_q      <= drop_item;
				out_last_q <= 1'b1;
			end
			ppu_pkg::OP_OUT_REPORT: begin
				out_q      <= rep_item;
				out_last_q <= cmd.last;
			end
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q       <= '0;
			show_q       <= '0;
			count_q      <= '0;
			enabled_q    <= 1'b1;
			grav_q       <= ppu_pkg::GRAV_RESET;
			drag_q       <= ppu_pkg::DRAG_RESET;
			out_valid_q  <= 1'b0;
			div_run_q    <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					ppu_pkg::REG_EFFECTS: enabled_q <= cfg_data[0];
					ppu_pkg::REG_GRAVITY: grav_q    <= cfg_data[30:0];
					ppu_pkg::REG_DRAG:    drag_q    <= cfg_data[16:0];
					default: ;
				endcase
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (cmd.op)
				ppu_pkg::OP_SCAN_CMP: begin
					if (cmd.idx == '0) free_found_q <= !live_q[cmd.idx];
					else if (!live_q[cmd.idx]) free_found_q <= 1'b1;
				end
				ppu_pkg::OP_CREATE_WR: begin
					live_q[cr_sel] <= 1'b1;
					if (free_found_q) count_q <= count_q + 1'b1;
				end
				ppu_pkg::OP_DIV_INIT: begin
					div_run_q <= !expire && wk_q.init != '0 &&
						wk_q.rem < {1'b0, wk_q.init};
				end
				ppu_pkg::OP_TICK_WR: begin
					if (expire) begin
						live_q[cmd.idx] <= 1'b0;
						show_q[cmd.idx] <= (wk_q.init != '0) || (wk_q.rem != '0);
						if (count_q != '0) count_q <= count_q - 1'b1;
					end else begin
						show_q[cmd.idx] <= 1'b0;
					end
				end
				ppu_pkg::OP_CLR_SHOW: show_q[cmd.idx] <= 1'b0;
				default: ;
			endcase
		end
	end

	assign stat.live     = live_q[cmd.idx];
	assign stat.enabled  = enabled_q;
	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign out_item      = out_q;
	assign out_last      = out_last_q;
endmodule
`default_nettype wire

FILE: src/particle_pool_update_core.sv
// Particle pool update core: top level joining ppu_ctrl and ppu_dpath (ppu_pkg).
// Create: only a drop result when disabled, else a scan of all slots (slot memory read per slot).
// Tick: each live slot is loaded and updated (6 multiplies, 16-step divider,
// 4 blend steps) and written back, a free slot is skipped; then the slots are reported.
// One item at a time; arst_n clears live flags and counts at once, no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module particle_pool_update_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// pos_x, pos_y, vel_x, vel_y, rotation, rotation_speed, size, lifetime,
	// colors, particle_type, frame_time
	input  wire logic [ppu_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	// cmd
	input  wire logic                                s_axis_tuser,
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// slot, alive, out_pos_x, out_pos_y, out_rotation, out_size, out_color,
	// out_type, live_total
	output logic [ppu_pkg::OUT_DATA_W-1:0]           m_axis_tdata,
	output logic                                     m_axis_tlast,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [ppu_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [ppu_pkg::CFG_DATA_W-1:0]      cfg_data
);
	ppu_pkg::ctl_cmd_t  ctl_cmd;
	ppu_pkg::dp_stat_t  dp_stat;
	ppu_pkg::out_item_t out_item;

	assign cfg_ready = 1'b1;

	ppu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_cmd   (s_axis_tuser),
		.in_ready (s_axis_tready),
		.stat     (dp_stat),
		.cmd      (ctl_cmd)
	);

	ppu_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (ctl_cmd),
		.stat      (dp_stat),
		.in_item   (ppu_pkg::in_item_t'(s_axis_tdata)),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_item  (out_item),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = out_item;

	`PPU_ASSERT(a_accept_capture, (s_axis_tvalid && s_axis_tready) |-> (ctl_cmd.op == ppu_pkg::OP_CAPTURE), "request accepted without capture")
	`PPU_ASSERT(a_out_no_overwrite, (ctl_cmd.op == ppu_pkg::OP_OUT_REPORT || ctl_cmd.op == ppu_pkg::OP_OUT_CREATE || ctl_cmd.op == ppu_pkg::OP_OUT_DROP) |-> (!m_axis_tvalid || m_axis_tready), "result overwritten")
	`PPU_ASSERT(a_live_bound, m_axis_tvalid |-> (out_item.live_total <= 7'(ppu_pkg::NUM_SLOTS)), "live count above pool size")
	`PPU_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !m_axis_tvalid, "result valid in reset")
endmodule
`default_nettype wire
